// ===== sv/utf16_to_utf8_transcoder_core_macros.svh =====
// assertion helpers shared by the transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define UTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utt assertion failed");

// next-cycle implication, checked outside reset
`define UTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utt assertion failed");

`endif

// ===== sv/utt_pkg.sv =====
`timescale 1ns / 1ps

package utt_pkg;

   localparam int UttQDepth = 4;
   localparam int UttQPtrW  = $clog2(UttQDepth);
   localparam int UttQCntW  = $clog2(UttQDepth + 1);

   localparam logic [15:0] HiFirst  = 16'hD800;
   localparam logic [15:0] HiLast   = 16'hDBFF;
   localparam logic [15:0] LoFirst  = 16'hDC00;
   localparam logic [15:0] LoLast   = 16'hDFFF;
   localparam logic [20:0] SuppBase = 21'h10000;
   localparam int          SurShift = 10;

   // one queued job: an optional flushed high surrogate, then an optional code point
   typedef struct packed {
      logic        prefix_valid;
      logic [9:0]  prefix_offset;
      logic        main_valid;
      logic [20:0] main_cp;
      logic        last;
   } job_type;

   // index of the final byte of the utf-8 form of cp
   function automatic logic [1:0] utt_last_idx(input logic [20:0] cp);
      logic [1:0] r;
      if (cp < 21'h80) r = 2'd0;
      else if (cp < 21'h800) r = 2'd1;
      else if (cp < SuppBase) r = 2'd2;
      else r = 2'd3;
      return r;
   endfunction

   // byte idx of the utf-8 form of cp
   function automatic logic [7:0] utt_byte(input logic [20:0] cp,
                                           input logic [1:0]  last_idx,
                                           input logic [1:0]  idx);
      logic [1:0] sel;
      logic [5:0] chunk;
      logic [7:0] r;
      sel = last_idx - idx;
      case (sel)
         2'd0:    chunk = cp[5:0];
         2'd1:    chunk = cp[11:6];
         2'd2:    chunk = cp[17:12];
         default: chunk = {3'b000, cp[20:18]};
      endcase
      if (idx == 2'd0) begin
         case (last_idx)
            2'd0:    r = {1'b0, cp[6:0]};
            2'd1:    r = {3'b110, cp[10:6]};
            2'd2:    r = {4'b1110, cp[15:12]};
            default: r = {5'b11110, cp[20:18]};
         endcase
      end else begin
         r = {2'b10, chunk};
      end
      return r;
   endfunction

endpackage

// ===== sv/utt_front.sv =====
`timescale 1ns / 1ps

module utt_front
   import utt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [15:0] req_code_unit,
   input  logic        req_string_last,
   input  logic        q_full,
   output logic        q_push,
   output job_type     q_job
);

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_offset_ff, held_offset_in;
   logic       accept;
   logic       is_hi, is_lo;
   job_type    job;

   assign accept = req_push && !q_full;
   assign is_hi  = (req_code_unit >= HiFirst) && (req_code_unit <= HiLast);
   assign is_lo  = (req_code_unit >= LoFirst) && (req_code_unit <= LoLast);

   always_comb begin
      job            = '0;
      job.last       = req_string_last;
      held_valid_in  = held_valid_ff;
      held_offset_in = held_offset_ff;
      if (held_valid_ff && is_lo) begin
         // surrogate pair
         job.main_valid = 1'b1;
         job.main_cp    = SuppBase + {1'b0, held_offset_ff, req_code_unit[9:0]};
         held_valid_in  = 1'b0;
         held_offset_in = '0;
      end else begin
         if (held_valid_ff) begin
            job.prefix_valid  = 1'b1;
            job.prefix_offset = held_offset_ff;
            held_valid_in     = 1'b0;
            held_offset_in    = '0;
         end
         if (is_hi && !req_string_last) begin
            held_valid_in  = 1'b1;
            held_offset_in = req_code_unit[9:0];
         end else begin
            job.main_valid = 1'b1;
            job.main_cp    = {5'd0, req_code_unit};
         end
      end
   end

   assign q_job  = job;
   assign q_push = accept && (job.prefix_valid || job.main_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff  <= 1'b0;
         held_offset_ff <= '0;
      end else if (accept) begin
         held_valid_ff  <= held_valid_in;
         held_offset_ff <= held_offset_in;
      end
   end

endmodule

// ===== sv/utt_queue.sv =====
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_core_macros.svh"

module utt_queue
   import utt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_job
);

   job_type               entry_ff [UttQDepth];
   logic [UttQPtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [UttQCntW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   assign full    = (count_ff == UttQCntW'(UttQDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

   `UTT_ASSERT_NOW(a_q_no_push_full, clock, reset, push, !full)
   `UTT_ASSERT_NOW(a_q_no_pop_empty, clock, reset, pop, !empty)
   `UTT_ASSERT_NOW(a_q_count_range, clock, reset, 1'b1,
                   count_ff <= UttQCntW'(UttQDepth))

endmodule

// ===== sv/utt_back.sv =====
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_core_macros.svh"

module utt_back
   import utt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  job_type    q_job,
   output logic       q_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);

   job_type     job_ff;
   logic        job_valid_ff;
   logic        in_prefix_ff;
   logic [1:0]  idx_ff;
   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_run_last_ff, out_string_end_ff;

   logic [20:0] seg_cp;
   logic [1:0]  seg_last_idx;
   logic        seg_end, job_done, advance, load;
   logic [7:0]  cur_byte;

   // the flushed high surrogate always takes three bytes
   assign seg_cp       = in_prefix_ff ? {5'd0, 6'b110110, job_ff.prefix_offset}
                                      : job_ff.main_cp;
   assign seg_last_idx = utt_last_idx(seg_cp);
   assign seg_end      = (idx_ff == seg_last_idx);
   assign job_done     = seg_end && (!in_prefix_ff || !job_ff.main_valid);
   assign cur_byte     = utt_byte(seg_cp, seg_last_idx, idx_ff);

   assign advance = job_valid_ff && (!out_valid_ff || rsp_pop);
   assign load    = !q_empty && (!job_valid_ff || (advance && job_done));
   assign q_pop   = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         in_prefix_ff <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            job_valid_ff <= 1'b1;
            in_prefix_ff <= q_job.prefix_valid;
            idx_ff       <= '0;
         end else if (advance) begin
            if (job_done) begin
               job_valid_ff <= 1'b0;
            end else if (seg_end) begin
               in_prefix_ff <= 1'b0;
               idx_ff       <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) job_ff <= q_job;
      if (advance) begin
         out_byte_ff       <= cur_byte;
         out_run_last_ff   <= job_done;
         out_string_end_ff <= job_done && job_ff.last;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = out_run_last_ff;
   assign rsp_string_end = out_string_end_ff;

   `UTT_ASSERT_NOW(a_back_idx_range, clock, reset, job_valid_ff, idx_ff <= seg_last_idx)
   `UTT_ASSERT_NOW(a_back_end_on_run, clock, reset, out_valid_ff && out_string_end_ff,
                   out_run_last_ff)
   `UTT_ASSERT_NEXT(a_back_prefix_len, clock, reset,
                    advance && in_prefix_ff && !seg_end, in_prefix_ff)

endmodule

// ===== sv/utf16_to_utf8_transcoder_core.sv =====
`timescale 1ns / 1ps
// utf-16 to utf-8 transcoder
// request side: one utf-16 code unit per request on req_code_unit, with
//   req_string_last marking the final unit of a string; a request is taken on
//   a clock edge with req_push high and req_full low
// response side: one utf-8 byte per response on rsp_out_byte; rsp_run_last
//   marks the last byte caused by a request, rsp_string_end the last byte of
//   the string; a byte is taken on an edge with rsp_pop high and rsp_empty low
// a high surrogate is held until the next unit; it yields nothing on its own
//   unless it ends the string or is followed by a non low surrogate
// when the back end is idle, the first byte of a request passes the queue
//   write, the job load and the output register before it is visible
// throughput: one byte per cycle from the serializer while the consumer
//   keeps up, with each request yielding 0 to 6 bytes; the front takes a
//   request every cycle while the 4-entry job queue has room
// reset clears the held surrogate, the job queue and the output register
// a stalled consumer holds the output byte; the queue then fills and
//   req_full rises, and no request or byte is lost

module utf16_to_utf8_transcoder_core
   import utt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_code_unit,
   input  logic        req_string_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_string_end
);

   // front to queue
   logic    q_push;
   job_type q_push_job;
   // queue to back
   logic    q_full, q_empty, q_pop;
   job_type q_pop_job;

   // classify each code unit and track the held high surrogate
   utt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_code_unit   (req_code_unit),
      .req_string_last (req_string_last),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (q_push_job)
   );

   // short job queue decouples classification from byte serialization
   utt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_job  (q_pop_job)
   );

   // expand each job into utf-8 bytes, one per cycle while the consumer keeps up, into the output register
   utt_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_job          (q_pop_job),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

   // full is conservative: a held unit needs no queue entry but still waits
   assign req_full = q_full;

endmodule

// ===== verif/utt_byte_stream_checker.sv =====
`timescale 1ns / 1ps

module utt_byte_stream_checker
   import utt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [15:0] req_code_unit,
   input  logic        req_string_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_string_end,
   output int          fail_count,
   output int          pending_bytes,
   output int          bytes_checked
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } utf8_byte_type;

   utf8_byte_type pending_utf8[$];

   // bytes produced by the code unit being predicted
   utf8_byte_type unit_bytes[6];
   int            unit_len;

   // surrogate held back from the previous unit
   logic       held_valid;
   logic [9:0] held_offset;

   task automatic add_byte(input logic [7:0] b);
      unit_bytes[unit_len] = '{out_byte: b, run_last: 1'b0, string_end: 1'b0};
      unit_len++;
   endtask

   task automatic encode_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         add_byte({1'b0, cp[6:0]});
      end else if (cp < 21'h800) begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
         add_byte({4'b1110, cp[15:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end else begin
         add_byte({5'b11110, cp[20:18]});
         add_byte({2'b10, cp[17:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endtask

   task automatic transcode_unit(input logic [15:0] cu, input logic last);
      logic is_hi;
      logic is_lo;
      logic paired;
      is_hi = (cu >= HiFirst) && (cu <= HiLast);
      is_lo = (cu >= LoFirst) && (cu <= LoLast);
      paired = 1'b0;
      unit_len = 0;
      if (held_valid) begin
         if (is_lo) begin
            encode_code_point(SuppBase + {1'b0, held_offset, cu[9:0]});
            paired = 1'b1;
         end else begin
            // orphaned high surrogate goes out on its own
            encode_code_point({5'b0, HiFirst[15:10], held_offset});
         end
         held_valid = 1'b0;
         held_offset = '0;
      end
      if (!paired) begin
         if (is_hi && !last) begin
            held_valid = 1'b1;
            held_offset = cu[9:0];
         end else begin
            encode_code_point({5'b0, cu});
         end
      end
      if (unit_len > 0) begin
         unit_bytes[unit_len - 1].run_last = 1'b1;
         unit_bytes[unit_len - 1].string_end = last;
      end
      for (int i = 0; i < unit_len; i++) pending_utf8 = {pending_utf8, unit_bytes[i]};
   endtask

   initial begin
      fail_count = 0;
      pending_bytes = 0;
      bytes_checked = 0;
      held_valid = 1'b0;
      held_offset = '0;
   end

   always @(posedge clock) begin
      utf8_byte_type seen;
      utf8_byte_type want;
      seen = '{out_byte: rsp_out_byte, run_last: rsp_run_last, string_end: rsp_string_end};
      if (reset) begin
         pending_utf8.delete();
         held_valid = 1'b0;
         held_offset = '0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            bytes_checked++;
            if (pending_utf8.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected byte %02h run_last %0b string_end %0b",
                        $time, seen.out_byte, seen.run_last, seen.string_end);
            end else begin
               want = pending_utf8.pop_front();
               if (seen !== want) begin
                  fail_count++;
                  $display("%0t: expected byte %02h run_last %0b string_end %0b, got %02h %0b %0b",
                           $time, want.out_byte, want.run_last, want.string_end,
                           seen.out_byte, seen.run_last, seen.string_end);
               end
            end
         end
         if (req_push && !req_full) transcode_unit(req_code_unit, req_string_last);
      end
      pending_bytes = pending_utf8.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import utt_pkg::*;
();

   // longest run of cycles with no request and no byte taken before giving up
   localparam int QuietLimit = 2000;
   localparam int RandomUnits = 200;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [15:0] req_code_unit;
   logic        req_string_last;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_string_end;

   int fail_count;
   int pending_bytes;
   int bytes_checked;
   int units_sent;
   int strings_sent;
   int quiet_cycles;

   // idle windows switch on and off so that back-to-back stretches also occur
   bit req_idle_on;

   utf16_to_utf8_transcoder_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_code_unit   (req_code_unit),
      .req_string_last (req_string_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_end  (rsp_string_end)
   );

   // watches both channels, predicts the utf-8 stream and compares it
   utt_byte_stream_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_code_unit   (req_code_unit),
      .req_string_last (req_string_last),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_string_end  (rsp_string_end),
      .fail_count      (fail_count),
      .pending_bytes   (pending_bytes),
      .bytes_checked   (bytes_checked)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // one request: optional idle gap, then hold push until the edge that takes it
   // entered and left at a falling edge
   task automatic send_unit(input logic [15:0] cu, input logic last);
      int gap;
      bit took;
      gap = req_idle_on ? $urandom_range(0, 14) : 0;
      if ($urandom_range(0, 39) == 0) req_idle_on = !req_idle_on;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_code_unit <= cu;
      req_string_last <= last;
      do begin
         @(posedge clock);
         took = !req_full;
         @(negedge clock);
      end while (!took);
      units_sent++;
      if (last) strings_sent++;
   endtask

   // response side: a random stall before each byte, stall windows toggle
   initial begin
      int stall;
      bit got;
      bit rsp_idle_on;
      rsp_pop = 1'b0;
      rsp_idle_on = 1'b1;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 14) : 0;
         if ($urandom_range(0, 29) == 0) rsp_idle_on = !rsp_idle_on;
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do begin
            @(posedge clock);
            got = !rsp_empty;
            @(negedge clock);
         end while (!got);
      end
   end

   // watchdog: any cycle that moves a request or a byte restarts the count
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t: no progress for %0d cycles", $time, QuietLimit);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int len;
      int kind;
      int directed_units;
      logic fin;
      logic [15:0] cu;
      logic [15:0] lo;

      reset = 1'b1;
      req_push = 1'b0;
      req_code_unit = '0;
      req_string_last = 1'b0;
      units_sent = 0;
      strings_sent = 0;
      quiet_cycles = 0;
      req_idle_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: boundaries of the one-, two- and three-byte utf-8 lengths, zero, all-ones
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      // lowest and highest surrogate pairs, the second one ending the string
      send_unit(HiFirst, 1'b0);
      send_unit(LoFirst, 1'b0);
      send_unit(HiLast, 1'b0);
      send_unit(LoLast, 1'b1);
      // high surrogate on the last unit goes out at once
      send_unit(HiFirst, 1'b1);
      // lone low surrogates at both ends of the range
      send_unit(LoFirst, 1'b0);
      send_unit(LoLast, 1'b0);
      // held high then ascii, then held high then a three-byte unit (six bytes)
      send_unit(16'hDA55, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'hDB00, 1'b0);
      send_unit(16'hE000, 1'b0);
      // held high replaced by another high, which then pairs
      send_unit(16'hD812, 1'b0);
      send_unit(16'hD934, 1'b0);
      send_unit(16'hDD00, 1'b1);
      // held high flushed by zero at string end, and by a high at string end
      send_unit(16'hD9AA, 1'b0);
      send_unit(16'h0000, 1'b1);
      send_unit(HiLast, 1'b0);
      send_unit(HiLast, 1'b1);
      directed_units = units_sent;

      // random strings: mostly well-formed text, some broken surrogates and noise
      while (units_sent < directed_units + RandomUnits) begin
         len = $urandom_range(1, 10);
         for (int k = 0; k < len; k++) begin
            fin = (k == len - 1);
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
               send_unit(16'($urandom_range(0, 16'h7F)), fin);
            end else if (kind < 40) begin
               send_unit(16'($urandom_range(16'h80, 16'h7FF)), fin);
            end else if (kind < 55) begin
               cu = 16'($urandom_range(16'h800, 16'hFFFF));
               // keep this class out of the surrogate range
               if (cu >= HiFirst && cu <= LoLast) cu = 16'($urandom_range(16'hE000, 16'hFFFF));
               send_unit(cu, fin);
            end else if (kind < 80) begin
               cu = HiFirst | 16'($urandom_range(0, 16'h3FF));
               lo = LoFirst | 16'($urandom_range(0, 16'h3FF));
               send_unit(cu, 1'b0);
               send_unit(lo, fin);
            end else if (kind < 87) begin
               send_unit(HiFirst | 16'($urandom_range(0, 16'h3FF)), fin);
            end else if (kind < 92) begin
               send_unit(LoFirst | 16'($urandom_range(0, 16'h3FF)), fin);
            end else begin
               send_unit(16'($urandom_range(0, 16'hFFFF)), fin);
            end
         end
      end
      req_push <= 1'b0;

      // drain, then leave room for any stray byte to show up
      while (pending_bytes != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      $display("sent %0d code units in %0d strings (pairs, lone and orphaned surrogates)",
               units_sent, strings_sent);
      $display("compared %0d utf-8 bytes under random stalls on both sides", bytes_checked);
      if (fail_count == 0 && pending_bytes == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
